// ===== sv/antisymmetric_index_rank_assert.svh =====
`ifndef ANTISYMMETRIC_INDEX_RANK_ASSERT_SVH
`define ANTISYMMETRIC_INDEX_RANK_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define AIR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define AIR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define AIR_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/air_pkg.sv =====
package air_pkg;

   localparam int MAX_DEGREE    = 4;
   localparam int MAX_DIMENSION = 4;
   localparam int INDEX_FIELDS  = 4;

   localparam int IDX_W    = 3;
   localparam int CFG_W    = 3;
   localparam int SLOT_W   = 3;
   localparam int SORTED_W = 2;
   localparam int SIGN_W   = 2;
   localparam int BINOM_W  = 6;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_SPACE_DIMENSION = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FORM_DEGREE     = 1'd1;

   localparam logic KIND_RANK   = 1'b0;
   localparam logic KIND_UNRANK = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;
   localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
   localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

   localparam logic [CFG_W-1:0] DIMENSION_RESET = 3'd4;
   localparam logic [CFG_W-1:0] DEGREE_RESET    = 3'd2;

   typedef struct packed {
      logic                          status;
      logic signed [SIGN_W-1:0]      sign;
      logic [SLOT_W-1:0]             slot;
      logic [3:0][SORTED_W-1:0]      sorted;
   } result_type;

   // Binomial coefficient C(a,k) for a below eight; zero for k above a.
   localparam logic [BINOM_W-1:0] BINOM [8][8] = '{
      '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
      '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
      '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
   };

   function automatic logic [BINOM_W-1:0] binom(input logic [2:0] a, input logic [2:0] k);
      return BINOM[a][k];
   endfunction

endpackage

// ===== sv/antisymmetric_index_rank.sv =====
// A req word accepted at a clock edge sits in the input register and moves into the
// result register, and onto rsp, once the result register is free.
// Throughput: one word per cycle; the input register keeps loading while a result
// waits on rsp_tready, so the stream stalls only when both registers are full.
// Reset (synchronous, active high) empties both registers and sets
// space_dimension to 4 and form_degree to 2.
module antisymmetric_index_rank (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [2:0] first_index, [5:3] second_index, [8:6] third_index,
   // [11:9] fourth_index, [14:12] slot_request, [15] zero
   input  logic [air_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [0] kind
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] sign, [4:2] slot, [6:5] sorted_first, [8:7] sorted_second,
   // [10:9] sorted_third, [12:11] sorted_fourth, [15:13] zero
   output logic [air_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] status
   output logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [air_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [air_pkg::CFG_W-1:0]            csr_data
);

   logic [air_pkg::CFG_W-1:0] dim_ff, dim_in;
   logic [air_pkg::CFG_W-1:0] deg_ff, deg_in;

   logic                        in_valid_ff, in_valid_in;
   logic                        in_kind_ff;
   logic [3:0][air_pkg::IDX_W-1:0] in_idx_ff;
   logic [air_pkg::SLOT_W-1:0]  in_slot_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   air_pkg::result_type         result_ff, result_in;

   logic advance;
   logic req_take;

   // Handshake: the input register moves on whenever the result register is free.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      dim_in = dim_ff;
      deg_in = deg_ff;
      if (csr_valid) begin
         case (csr_index)
            air_pkg::REG_SPACE_DIMENSION: dim_in = csr_data;
            air_pkg::REG_FORM_DEGREE:     deg_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= air_pkg::DIMENSION_RESET;
         deg_ff       <= air_pkg::DEGREE_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dim_ff       <= dim_in;
         deg_ff       <= deg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= req_tuser;
         in_idx_ff[0] <= req_tdata[2:0];
         in_idx_ff[1] <= req_tdata[5:3];
         in_idx_ff[2] <= req_tdata[8:6];
         in_idx_ff[3] <= req_tdata[11:9];
         in_slot_ff   <= req_tdata[14:12];
      end
      if (advance && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   // Rank and unrank datapath between the two registers.
   logic                          cfg_bad;
   logic [3:0]                    used;
   logic                          idx_bad;
   logic                          dup;
   logic                          parity;
   logic [3:0][2:0]               pos;
   logic [air_pkg::BINOM_W-1:0]   term_sum;
   logic [air_pkg::BINOM_W-1:0]   total;
   logic [air_pkg::BINOM_W-1:0]   rank_full;
   logic                          slot_bad;
   logic [3:0][air_pkg::SORTED_W-1:0] unrank_idx;

   assign cfg_bad = (5'(deg_ff) > 5'(air_pkg::MAX_DEGREE)) ||
                    (5'(deg_ff) > 5'(air_pkg::INDEX_FIELDS)) ||
                    (5'(dim_ff) > 5'(air_pkg::MAX_DIMENSION));
   assign total   = air_pkg::binom(dim_ff, deg_ff);

   always_comb begin
      idx_bad  = 1'b0;
      dup      = 1'b0;
      parity   = 1'b0;
      term_sum = '0;
      for (int i = 0; i < 4; i++) begin
         used[i] = 3'(i) < deg_ff;
      end
      for (int i = 0; i < 4; i++) begin
         if (used[i] && (in_idx_ff[i] >= dim_ff)) begin
            idx_bad = 1'b1;
         end
         pos[i] = '0;
         for (int k = 0; k < 4; k++) begin
            if (used[k] && (k != i) && (in_idx_ff[k] < in_idx_ff[i])) begin
               pos[i] = pos[i] + 3'd1;
            end
         end
      end
      // Parity is that of the number of inversions; any equal pair kills the sign.
      for (int i = 0; i < 4; i++) begin
         for (int j = i + 1; j < 4; j++) begin
            if (used[j]) begin
               if (in_idx_ff[i] > in_idx_ff[j]) begin
                  parity = ~parity;
               end
               if (in_idx_ff[i] == in_idx_ff[j]) begin
                  dup = 1'b1;
               end
            end
         end
      end
      // With distinct indices, the one with pos smaller ones sits at that place
      // of the sorted tuple: rank = C(n,p) - 1 - sum C(n-1-s_i, p-i).
      for (int i = 0; i < 4; i++) begin
         if (used[i]) begin
            term_sum = term_sum + air_pkg::binom(dim_ff - 3'd1 - in_idx_ff[i],
                                                 deg_ff - pos[i]);
         end
      end
      rank_full = total - 6'd1 - term_sum;
   end

   // Unrank by decoding the complemented rank as a combinatorial number,
   // one position per step, largest coefficient first.
   always_comb begin
      logic [air_pkg::BINOM_W-1:0] rem;
      logic [2:0]                  prev;
      logic [2:0]                  pick;
      logic [2:0]                  k;
      rem      = total - 6'd1 - 6'(in_slot_ff);
      prev     = dim_ff;
      slot_bad = 6'(in_slot_ff) >= total;
      for (int i = 0; i < 4; i++) begin
         k    = deg_ff - 3'(i);
         pick = '0;
         for (int c = 0; c < 7; c++) begin
            if ((3'(c) < prev) && (air_pkg::binom(3'(c), k) <= rem)) begin
               pick = 3'(c);
            end
         end
         unrank_idx[i] = '0;
         if (used[i]) begin
            rem           = rem - air_pkg::binom(pick, k);
            prev          = pick;
            unrank_idx[i] = 2'(dim_ff - 3'd1 - pick);
         end
      end
   end

   always_comb begin
      result_in = '0;
      if (cfg_bad) begin
         result_in.status = air_pkg::STATUS_ERR;
      end else if (in_kind_ff == air_pkg::KIND_RANK) begin
         if (idx_bad) begin
            result_in.status = air_pkg::STATUS_ERR;
         end else if (!dup) begin
            result_in.sign = parity ? air_pkg::SIGN_NEG : air_pkg::SIGN_POS;
            result_in.slot = rank_full[air_pkg::SLOT_W-1:0];
         end
      end else begin
         if (slot_bad) begin
            result_in.status = air_pkg::STATUS_ERR;
         end else begin
            result_in.sign   = air_pkg::SIGN_POS;
            result_in.slot   = in_slot_ff;
            result_in.sorted = unrank_idx;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.status;
   assign rsp_tdata  = {3'b000, result_ff.sorted, result_ff.slot, result_ff.sign};

endmodule

// ===== sv/air_checker.sv =====
`include "antisymmetric_index_rank_assert.svh"

module air_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [air_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              rsp_tuser
);

   `AIR_ASSERT_ALWAYS_NXT(a_reset_empties, clock, reset, !rsp_tvalid, "rsp word after reset")
   `AIR_ASSERT_NXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped")
   `AIR_ASSERT_IMP(a_error_clear, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "error word not clear")
   `AIR_ASSERT_IMP(a_zero_sign_clear, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == 2'b00), rsp_tdata[15:2] == '0, "zero sign with data")
   `AIR_ASSERT_IMP(a_sign_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'b10, "bad sign code")

endmodule

bind antisymmetric_index_rank air_checker u_air_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
